FILE: hw/rtl/secp_pkg.sv
// ----------------------------------------------------------------------------
// SMTP EHLO capability parser package
// Shared types, character constants, keyword tables and the per-byte
// update functions of the parser.
// ----------------------------------------------------------------------------
package secp_pkg;

    localparam int KW_COUNT       = 7;
    localparam int KW_EXACT_COUNT = 5;
    localparam int KW_SIZE        = 5;
    localparam int KW_AUTH        = 6;
    localparam int KW_MAX_LEN     = 10;

    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    // Line classification.
    localparam logic [1:0] LK_UNDECIDED = 2'd0;
    localparam logic [1:0] LK_CONT      = 2'd1;
    localparam logic [1:0] LK_LAST      = 2'd2;
    localparam logic [1:0] LK_OTHER     = 2'd3;

    // SIZE argument parsing phases.
    localparam logic [2:0] SP_WAIT_SPACE = 3'd0;
    localparam logic [2:0] SP_WHITE      = 3'd1;
    localparam logic [2:0] SP_SIGN       = 3'd2;
    localparam logic [2:0] SP_DIGITS     = 3'd3;
    localparam logic [2:0] SP_DONE       = 3'd4;

    localparam logic [7:0] LEAD_TEXT [0:2] = '{8'h32, 8'h35, 8'h30};

    // PIPELINING, STARTTLS, 8BITMIME, DSN, SMTPUTF8, SIZE, AUTH
    localparam logic [7:0] KW_TEXT [0:KW_COUNT-1][0:KW_MAX_LEN-1] = '{
        '{"P", "I", "P", "E", "L", "I", "N", "I", "N", "G"},
        '{"S", "T", "A", "R", "T", "T", "L", "S", 8'h00, 8'h00},
        '{"8", "B", "I", "T", "M", "I", "M", "E", 8'h00, 8'h00},
        '{"D", "S", "N", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"S", "M", "T", "P", "U", "T", "F", "8", 8'h00, 8'h00},
        '{"S", "I", "Z", "E", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"A", "U", "T", "H", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
    };

    localparam logic [3:0] KW_LEN [0:KW_COUNT-1] =
        '{4'd10, 4'd8, 4'd8, 4'd3, 4'd8, 4'd4, 4'd4};

    typedef struct packed {
        logic [2:0]          prefix_pos;
        logic [1:0]          line_kind;
        logic [KW_COUNT-1:0] candidates;
        logic [3:0]          kw_length;
        logic                pending_cr;
        logic [2:0]          size_phase;
        logic                size_negative;
        logic [63:0]         size_acc;
        logic                size_digit_seen;
        logic                size_overflow;
        logic [KW_COUNT-1:0] cap_flags;
        logic [63:0]         max_size;
        logic                reply_finished;
        logic                size_error;
    } parser_state_t;

    localparam parser_state_t STATE_INIT = '{
        prefix_pos:      3'd0,
        line_kind:       LK_UNDECIDED,
        candidates:      {KW_COUNT{1'b1}},
        kw_length:       4'd0,
        pending_cr:      1'b0,
        size_phase:      SP_WAIT_SPACE,
        size_negative:   1'b0,
        size_acc:        64'd0,
        size_digit_seen: 1'b0,
        size_overflow:   1'b0,
        cap_flags:       {KW_COUNT{1'b0}},
        max_size:        64'd0,
        reply_finished:  1'b0,
        size_error:      1'b0
    };

    function automatic parser_state_t clear_line(parser_state_t s);
        parser_state_t r;
        r                 = s;
        r.prefix_pos      = 3'd0;
        r.line_kind       = LK_UNDECIDED;
        r.candidates      = {KW_COUNT{1'b1}};
        r.kw_length       = 4'd0;
        r.size_phase      = SP_WAIT_SPACE;
        r.size_negative   = 1'b0;
        r.size_acc        = 64'd0;
        r.size_digit_seen = 1'b0;
        r.size_overflow   = 1'b0;
        return r;
    endfunction

    function automatic parser_state_t size_byte(parser_state_t s, logic [7:0] c);
        parser_state_t r;
        logic          digit;
        logic          white;
        logic          take_num;
        logic [67:0]   wide;
        r        = s;
        digit    = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
        white    = (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
        take_num = 1'b0;
        case (s.size_phase)
            SP_WAIT_SPACE:
            begin
                if (c == CHAR_SPACE)
                begin
                    r.size_phase = SP_WHITE;
                end
            end
            SP_WHITE:
            begin
                if (!white)
                begin
                    if ((c == CHAR_PLUS) || (c == CHAR_MINUS))
                    begin
                        r.size_negative = (c == CHAR_MINUS);
                        r.size_phase    = SP_SIGN;
                    end
                    else
                    begin
                        take_num = 1'b1;
                    end
                end
            end
            SP_SIGN, SP_DIGITS:
            begin
                take_num = 1'b1;
            end
            default:
            begin
            end
        endcase
        if (take_num)
        begin
            if (digit)
            begin
                // acc * 10 + d; any carry above bit 63 means the value overflowed.
                wide = {1'b0, s.size_acc, 3'b000} + {3'b000, s.size_acc, 1'b0}
                     + {60'd0, c[3:0] - CHAR_ZERO[3:0]};
                if (wide[67:64] != 4'd0)
                begin
                    r.size_overflow = 1'b1;
                end
                else
                begin
                    r.size_acc = wide[63:0];
                end
                r.size_digit_seen = 1'b1;
                r.size_phase      = SP_DIGITS;
            end
            else
            begin
                r.size_phase = SP_DONE;
            end
        end
        return r;
    endfunction

    function automatic parser_state_t content_byte(parser_state_t s, logic [7:0] c);
        parser_state_t r;
        r = s;
        if (s.line_kind != LK_OTHER)
        begin
            if (s.prefix_pos < 3'd4)
            begin
                if (s.prefix_pos < 3'd3)
                begin
                    if (c != LEAD_TEXT[s.prefix_pos[1:0]])
                    begin
                        r.line_kind = LK_OTHER;
                    end
                    else
                    begin
                        r.prefix_pos = s.prefix_pos + 3'd1;
                    end
                end
                else if (c == CHAR_MINUS)
                begin
                    r.line_kind  = LK_CONT;
                    r.prefix_pos = s.prefix_pos + 3'd1;
                end
                else if (c == CHAR_SPACE)
                begin
                    r.line_kind  = LK_LAST;
                    r.prefix_pos = s.prefix_pos + 3'd1;
                end
                else
                begin
                    r.line_kind = LK_OTHER;
                end
            end
            else
            begin
                for (int k = 0; k < KW_COUNT; k++)
                begin
                    if (s.kw_length < KW_LEN[k])
                    begin
                        if (c != KW_TEXT[k][s.kw_length])
                        begin
                            r.candidates[k] = 1'b0;
                        end
                    end
                    else if (k < KW_EXACT_COUNT)
                    begin
                        r.candidates[k] = 1'b0;
                    end
                end
                if (s.kw_length != 4'd15)
                begin
                    r.kw_length = s.kw_length + 4'd1;
                end
                r = size_byte(r, c);
            end
        end
        return r;
    endfunction

    function automatic parser_state_t end_line(parser_state_t s);
        parser_state_t r;
        logic          exact;
        r     = s;
        exact = 1'b0;
        if ((s.line_kind == LK_CONT) || (s.line_kind == LK_LAST))
        begin
            for (int k = 0; k < KW_EXACT_COUNT; k++)
            begin
                if (s.candidates[k] && (s.kw_length == KW_LEN[k]))
                begin
                    r.cap_flags[k] = 1'b1;
                    exact          = 1'b1;
                end
            end
            if (!exact && (s.kw_length >= 4'd4) && (s.size_phase != SP_WAIT_SPACE))
            begin
                if (s.candidates[KW_SIZE])
                begin
                    if (s.size_digit_seen && !s.size_overflow)
                    begin
                        r.max_size           = s.size_negative ? (64'd0 - s.size_acc)
                                                               : s.size_acc;
                        r.cap_flags[KW_SIZE] = 1'b1;
                    end
                    else
                    begin
                        r.size_error = 1'b1;
                    end
                end
                else if (s.candidates[KW_AUTH])
                begin
                    r.cap_flags[KW_AUTH] = 1'b1;
                end
            end
            if (s.line_kind == LK_LAST)
            begin
                r.reply_finished = 1'b1;
            end
        end
        return clear_line(r);
    endfunction

    // One received byte or a clear request applied to the whole parser state.
    function automatic parser_state_t parse_step(parser_state_t s, logic action,
                                                 logic [7:0] c);
        parser_state_t r;
        r = s;
        if (action)
        begin
            r = STATE_INIT;
        end
        else if (!s.reply_finished)
        begin
            if (s.pending_cr)
            begin
                if (c == CHAR_LF)
                begin
                    r.pending_cr = 1'b0;
                    r            = end_line(r);
                end
                else if (c == CHAR_CR)
                begin
                    r = content_byte(r, CHAR_CR);
                end
                else
                begin
                    // A CR without LF is an ordinary byte of the line.
                    r.pending_cr = 1'b0;
                    r            = content_byte(r, CHAR_CR);
                    r            = content_byte(r, c);
                end
            end
            else if (c == CHAR_CR)
            begin
                r.pending_cr = 1'b1;
            end
            else
            begin
                r = content_byte(r, c);
            end
        end
        return r;
    endfunction

endpackage

FILE: hw/rtl/secp_parser.sv
// ----------------------------------------------------------------------------
// SMTP EHLO capability parser core
// Holds the parser state and applies one byte or clear request per enabled
// cycle; presents the state that follows the current request.
// ----------------------------------------------------------------------------
module secp_parser
    import secp_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          step_en,
    input  logic          action,
    input  logic [7:0]    data_byte,
    output parser_state_t state_next
);

    parser_state_t state_reg;

    assign state_next = parse_step(state_reg, action, data_byte);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= STATE_INIT;
        end
        else if (step_en)
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: hw/rtl/smtp_ehlo_capability_parser_top.sv
// A byte accepted into the input register passes through the parser update
// into the result register, which drives m_tdata.
// Throughput: one byte per cycle; the input register, the parser update and
// the result register form a two-stage pipeline stalled only by m_tready.
// Reset clears all capability flags, the SIZE limit and the line state, and
// empties both pipeline registers.
// ----------------------------------------------------------------------------
// SMTP EHLO capability parser top level
// Stream wrapper: input register, parser core and result register.
// ----------------------------------------------------------------------------
module smtp_ehlo_capability_parser_top
    import secp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte
    input  logic [0:0]  s_tuser,   // action
    output logic        m_tvalid,
    input  logic        m_tready,
    // pipelining, starttls, eight_bit_mime, delivery_status, smtp_utf8,
    // size_ok, max_size[63:0], auth_listed, response_done, size_error
    output logic [79:0] m_tdata
);

    logic          in_valid_reg;
    logic          in_action_reg;
    logic [7:0]    in_byte_reg;
    logic          out_valid_reg;
    logic [79:0]   out_data_reg;
    logic          advance;
    parser_state_t state_next;

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    secp_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .step_en    (in_valid_reg && advance),
        .action     (in_action_reg),
        .data_byte  (in_byte_reg),
        .state_next (state_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_action_reg <= s_tuser[0];
            in_byte_reg   <= s_tdata;
        end
        if (advance && in_valid_reg)
        begin
            out_data_reg <= {7'd0,
                             state_next.size_error,
                             state_next.reply_finished,
                             state_next.cap_flags[KW_AUTH],
                             state_next.max_size,
                             state_next.cap_flags[KW_SIZE:0]};
        end
    end

endmodule

FILE: verif/smtp_ehlo_capability_parser_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SMTP EHLO capability parser stream testbench
// Feeds EHLO reply bytes and clear requests into the parser, tracks its own
// model of the capability flags and SIZE value, and checks every result word
// in order while both stream sides stall at random.
// ----------------------------------------------------------------------------
module smtp_ehlo_capability_parser_top_test;
    import secp_pkg::*;

    localparam int ITEM_TARGET   = 650;
    localparam int LONG_HOLD     = 80;
    localparam int KW_PIPELINING = 0;
    localparam int KW_STARTTLS   = 1;
    localparam int KW_8BITMIME   = 2;
    localparam int KW_DSN        = 3;
    localparam int KW_SMTPUTF8   = 4;
    localparam logic ACT_BYTE    = 1'b0;
    localparam logic ACT_CLEAR   = 1'b1;

    // Result word layout, pipelining in bit 0.
    typedef struct packed {
        logic        size_error;
        logic        response_done;
        logic        auth_listed;
        logic [63:0] max_size;
        logic        size_ok;
        logic        smtp_utf8;
        logic        delivery_status;
        logic        eight_bit_mime;
        logic        starttls;
        logic        pipelining;
    } capability_report_t;

    // Tracks the parser state and holds the capability reports still owed.
    class capability_tracker;
        capability_report_t  owed_reports[$];
        int                  errors;
        string               kw_names[KW_COUNT];
        string               lead_digits;
        logic [2:0]          lead_pos;
        logic [1:0]          kind;
        logic [KW_COUNT-1:0] cand;
        logic [3:0]          kw_len;
        logic                cr_held;
        logic [2:0]          phase;
        logic                neg;
        logic [63:0]         acc;
        logic                digit_seen;
        logic                ovf;
        logic [KW_COUNT-1:0] flags;
        logic [63:0]         limit;
        logic                done;
        logic                err;

        function new();
            kw_names    = '{"PIPELINING", "STARTTLS", "8BITMIME", "DSN", "SMTPUTF8",
                            "SIZE", "AUTH"};
            lead_digits = "250";
            errors      = 0;
            clear_all();
        endfunction

        function void clear_line();
            lead_pos   = 3'd0;
            kind       = LK_UNDECIDED;
            cand       = {KW_COUNT{1'b1}};
            kw_len     = 4'd0;
            phase      = SP_WAIT_SPACE;
            neg        = 1'b0;
            acc        = 64'd0;
            digit_seen = 1'b0;
            ovf        = 1'b0;
        endfunction

        function void clear_all();
            clear_line();
            cr_held = 1'b0;
            flags   = '0;
            limit   = 64'd0;
            done    = 1'b0;
            err     = 1'b0;
        endfunction

        function void size_arg_byte(logic [7:0] c);
            logic        is_digit;
            logic        is_white;
            logic        to_number;
            logic [67:0] widened;
            is_digit  = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
            is_white  = (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
            to_number = 1'b0;
            case (phase)
                SP_WAIT_SPACE:
                begin
                    if (c == CHAR_SPACE)
                    begin
                        phase = SP_WHITE;
                    end
                end
                SP_WHITE:
                begin
                    if ((c == CHAR_PLUS) || (c == CHAR_MINUS))
                    begin
                        neg   = (c == CHAR_MINUS);
                        phase = SP_SIGN;
                    end
                    else if (!is_white)
                    begin
                        to_number = 1'b1;
                    end
                end
                SP_SIGN, SP_DIGITS:
                begin
                    to_number = 1'b1;
                end
                default:
                begin
                end
            endcase
            if (to_number)
            begin
                if (is_digit)
                begin
                    widened = 68'(acc) * 68'd10 + 68'(c - CHAR_ZERO);
                    if (widened[67:64] != 4'd0)
                    begin
                        ovf = 1'b1;
                    end
                    else
                    begin
                        acc = widened[63:0];
                    end
                    digit_seen = 1'b1;
                    phase      = SP_DIGITS;
                end
                else
                begin
                    phase = SP_DONE;
                end
            end
        endfunction

        function void line_byte(logic [7:0] c);
            if (kind == LK_OTHER)
            begin
                return;
            end
            if (lead_pos < 3'd3)
            begin
                if (c != lead_digits[lead_pos])
                begin
                    kind = LK_OTHER;
                end
                else
                begin
                    lead_pos++;
                end
                return;
            end
            if (lead_pos == 3'd3)
            begin
                if (c == CHAR_MINUS)
                begin
                    kind = LK_CONT;
                end
                else if (c == CHAR_SPACE)
                begin
                    kind = LK_LAST;
                end
                else
                begin
                    kind = LK_OTHER;
                    return;
                end
                lead_pos = 3'd4;
                return;
            end
            for (int k = 0; k < KW_COUNT; k++)
            begin
                if (kw_len < kw_names[k].len())
                begin
                    if (c != kw_names[k][kw_len])
                    begin
                        cand[k] = 1'b0;
                    end
                end
                else if (k < KW_EXACT_COUNT)
                begin
                    cand[k] = 1'b0;
                end
            end
            if (kw_len != 4'd15)
            begin
                kw_len++;
            end
            size_arg_byte(c);
        endfunction

        function void end_of_line();
            logic exact;
            exact = 1'b0;
            if ((kind == LK_CONT) || (kind == LK_LAST))
            begin
                for (int k = 0; k < KW_EXACT_COUNT; k++)
                begin
                    if (cand[k] && (kw_len == kw_names[k].len()))
                    begin
                        flags[k] = 1'b1;
                        exact    = 1'b1;
                    end
                end
                // SIZE and AUTH count only once an argument was opened by a space.
                if (!exact && (kw_len >= 4'd4) && (phase != SP_WAIT_SPACE))
                begin
                    if (cand[KW_SIZE])
                    begin
                        if (digit_seen && !ovf)
                        begin
                            limit          = neg ? (64'd0 - acc) : acc;
                            flags[KW_SIZE] = 1'b1;
                        end
                        else
                        begin
                            err = 1'b1;
                        end
                    end
                    else if (cand[KW_AUTH])
                    begin
                        flags[KW_AUTH] = 1'b1;
                    end
                end
                if (kind == LK_LAST)
                begin
                    done = 1'b1;
                end
            end
            clear_line();
        endfunction

        // Applies one accepted request; returns 1 unless the byte was ignored.
        function bit note_request(logic act, logic [7:0] c);
            capability_report_t rep;
            bit                 effective;
            effective = act || !done;
            if (act)
            begin
                clear_all();
            end
            else if (!done)
            begin
                if (cr_held)
                begin
                    if (c == CHAR_LF)
                    begin
                        cr_held = 1'b0;
                        end_of_line();
                    end
                    else if (c == CHAR_CR)
                    begin
                        line_byte(CHAR_CR);
                    end
                    else
                    begin
                        cr_held = 1'b0;
                        line_byte(CHAR_CR);
                        line_byte(c);
                    end
                end
                else if (c == CHAR_CR)
                begin
                    cr_held = 1'b1;
                end
                else
                begin
                    line_byte(c);
                end
            end
            rep.pipelining      = flags[KW_PIPELINING];
            rep.starttls        = flags[KW_STARTTLS];
            rep.eight_bit_mime  = flags[KW_8BITMIME];
            rep.delivery_status = flags[KW_DSN];
            rep.smtp_utf8       = flags[KW_SMTPUTF8];
            rep.size_ok         = flags[KW_SIZE];
            rep.max_size        = limit;
            rep.auth_listed     = flags[KW_AUTH];
            rep.response_done   = done;
            rep.size_error      = err;
            owed_reports.push_back(rep);
            return effective;
        endfunction

        function void compare(string field, logic [63:0] want, logic [63:0] got);
            if (got !== want)
            begin
                $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
                errors++;
            end
        endfunction

        function void check_report(logic [79:0] word);
            capability_report_t want;
            capability_report_t got;
            if (owed_reports.size() == 0)
            begin
                $display("%0t: result expected none actual %h", $time, word);
                errors++;
                return;
            end
            want = owed_reports.pop_front();
            got  = word[72:0];
            compare("pipelining", want.pipelining, got.pipelining);
            compare("starttls", want.starttls, got.starttls);
            compare("eight_bit_mime", want.eight_bit_mime, got.eight_bit_mime);
            compare("delivery_status", want.delivery_status, got.delivery_status);
            compare("smtp_utf8", want.smtp_utf8, got.smtp_utf8);
            compare("size_ok", want.size_ok, got.size_ok);
            compare("max_size", want.max_size, got.max_size);
            compare("auth_listed", want.auth_listed, got.auth_listed);
            compare("response_done", want.response_done, got.response_done);
            compare("size_error", want.size_error, got.size_error);
            compare("padding", 64'd0, 64'(word[79:73]));
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic [0:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [79:0] m_tdata;

    capability_tracker board;
    int                bytes_taken = 0;
    bit                sender_steady = 1'b0;
    bit                long_hold_request = 1'b0;

    smtp_ehlo_capability_parser_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
        begin
            return 0;
        end
        if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(6, 30);
    endfunction

    function automatic string digit_run(int n);
        string s;
        s = "";
        for (int i = 0; i < n; i++)
        begin
            s = {s, $sformatf("%0d", $urandom_range(0, 9))};
        end
        return s;
    endfunction

    function automatic string size_text();
        string s;
        int    n;
        s = "SIZE";
        case ($urandom_range(0, 9))
            0:
            begin
                return s;
            end
            1:
            begin
                s = {s, $sformatf("%c", CHAR_TAB)};
            end
            2:
            begin
                s = {s, "X "};
            end
            default:
            begin
                s = {s, " "};
            end
        endcase
        n = $urandom_range(0, 3);
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(0, 5))
                0: s = {s, " "};
                1: s = {s, $sformatf("%c", CHAR_TAB)};
                2: s = {s, $sformatf("%c", 8'h0B)};
                3: s = {s, $sformatf("%c", 8'h0C)};
                4: s = {s, $sformatf("%c", CHAR_LF)};
                default: s = {s, $sformatf("%c ", CHAR_CR)};
            endcase
        end
        case ($urandom_range(0, 3))
            0: s = {s, "+"};
            1: s = {s, "-"};
            default:
            begin
            end
        endcase
        case ($urandom_range(0, 9))
            0:
            begin
            end
            1: s = {s, "0"};
            2: s = {s, "18446744073709551615"};
            3: s = {s, "18446744073709551616"};
            4: s = {s, "1844674407370955161", digit_run(1)};
            5: s = {s, digit_run($urandom_range(20, 24))};
            default: s = {s, digit_run($urandom_range(1, 12))};
        endcase
        case ($urandom_range(0, 7))
            0: s = {s, " 1000"};
            1: s = {s, "k"};
            2: s = {s, $sformatf("%c", CHAR_CR)};
            3: s = {s, "+"};
            default:
            begin
            end
        endcase
        return s;
    endfunction

    function automatic string capability_text();
        string s;
        int    n;
        case ($urandom_range(0, 23))
            0: return "PIPELINING";
            1: return "STARTTLS";
            2: return "8BITMIME";
            3: return "DSN";
            4: return "SMTPUTF8";
            5, 6, 7, 8, 9: return size_text();
            10: return "AUTH PLAIN LOGIN";
            11: return "AUTH";
            12: return "AUTH=LOGIN";
            13: return "AUTHENTICATE X";
            14: return "AUTH ";
            15: return "DSNX";
            16: return "PIPELININ";
            17: return "SMTPUTF8 ";
            18: return "8BITMIMEX";
            19: return "";
            20: return "CHUNKING";
            21: return {"DS", $sformatf("%c", CHAR_CR), "N"};
            22: return {"STARTTLS", $sformatf("%c", CHAR_CR)};
            default:
            begin
                s = "";
                n = $urandom_range(1, 16);
                for (int i = 0; i < n; i++)
                begin
                    s = {s, $sformatf("%c", 8'($urandom_range(8'h21, 8'h7E)))};
                end
                return s;
            end
        endcase
    endfunction

    task automatic send_request(logic act, logic [7:0] c);
        int idle;
        idle = sender_steady ? 0 : pick_gap();
        if (idle > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (idle) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= c;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        if (board.note_request(act, c))
        begin
            bytes_taken++;
        end
        @(negedge clk);
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++)
        begin
            send_request(ACT_BYTE, s[i]);
        end
    endtask

    task automatic send_noise();
        int n;
        n = $urandom_range(1, 8);
        repeat (n) send_request(ACT_BYTE, 8'($urandom_range(0, 255)));
    endtask

    // Stops offering requests until every owed report has come back.
    task automatic await_drain();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (board.owed_reports.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    task automatic send_reply();
        string crlf;
        int    lines;
        crlf = {$sformatf("%c", CHAR_CR), $sformatf("%c", CHAR_LF)};
        if ($urandom_range(0, 7) != 0)
        begin
            send_request(ACT_CLEAR, 8'($urandom_range(0, 255)));
        end
        lines = $urandom_range(0, 7);
        repeat (lines)
        begin
            case ($urandom_range(0, 11))
                0:
                begin
                    case ($urandom_range(0, 8))
                        0: send_text({"220 relay ready", crlf});
                        1: send_text({"25", crlf});
                        2: send_text({"250", crlf});
                        3: send_text({"2501 SIZE 5", crlf});
                        4: send_text({"25-0 DSN", crlf});
                        5: send_text({"250-", crlf});
                        6: send_text({$sformatf("%c", CHAR_CR), "250-DSN", crlf});
                        7: send_text({"X250-DSN", crlf});
                        default: send_text({"250-", $sformatf("%c", CHAR_CR), "DSN", crlf});
                    endcase
                end
                1:
                begin
                    send_noise();
                end
                default:
                begin
                    send_text({"250-", capability_text(), crlf});
                end
            endcase
        end
        if ($urandom_range(0, 5) != 0)
        begin
            send_text({"250 ", capability_text(), crlf});
            // Bytes after the closing line must leave the results alone.
            if ($urandom_range(0, 2) == 0)
            begin
                send_noise();
            end
        end
    endtask

    initial
    begin : stimulus
        int reply_count;
        board       = new();
        reply_count = 0;
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = 8'h00;
        s_tuser     = ACT_BYTE;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Field extremes, a foreign line with a lone CR, a negative SIZE on the
        // closing line, then a byte after the reply and a clear.
        send_request(ACT_CLEAR, 8'hFF);
        send_request(ACT_BYTE, 8'h00);
        send_request(ACT_BYTE, 8'hFF);
        send_text({$sformatf("%c", CHAR_CR), "x", $sformatf("%c", CHAR_CR),
                   $sformatf("%c", CHAR_LF)});
        send_text({"250 SIZE -1", $sformatf("%c", CHAR_CR), $sformatf("%c", CHAR_LF)});
        send_request(ACT_BYTE, "A");
        send_request(ACT_CLEAR, 8'h00);

        while (bytes_taken < ITEM_TARGET)
        begin
            sender_steady = ($urandom_range(0, 3) == 0);
            if (reply_count == 6)
            begin
                // The sink stalls on its own while replies keep coming.
                long_hold_request = 1'b1;
                sender_steady     = 1'b1;
            end
            if ((reply_count == 14) || ($urandom_range(0, 24) == 0))
            begin
                await_drain();
            end
            send_reply();
            reply_count++;
        end
        await_drain();
        repeat (8) @(negedge clk);
        if (board.errors == 0)
        begin
            $display("smtp_ehlo_capability_parser_top regression: pass");
        end
        else
        begin
            $display("smtp_ehlo_capability_parser_top regression: fail");
        end
        $finish;
    end

    initial
    begin : result_sink
        int hold_left;
        int steady_left;
        hold_left   = 0;
        steady_left = 0;
        m_tready    = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_hold_request)
            begin
                long_hold_request = 1'b0;
                hold_left         = LONG_HOLD;
            end
            else if ((hold_left == 0) && (steady_left == 0))
            begin
                if ($urandom_range(0, 149) == 0)
                begin
                    steady_left = $urandom_range(40, 160);
                end
                else if ($urandom_range(0, 3) == 0)
                begin
                    hold_left = pick_gap();
                end
            end
            if (hold_left > 0)
            begin
                m_tready <= 1'b0;
                hold_left--;
            end
            else
            begin
                m_tready <= 1'b1;
                if (steady_left > 0)
                begin
                    steady_left--;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            board.check_report(m_tdata);
        end
    end

    initial
    begin : watchdog
        #2_000_000;
        $display("smtp_ehlo_capability_parser_top regression: fail");
        $finish;
    end

endmodule
